@@ rtl/core/bfis_pkg.sv @@
// Package for the box filter image scaler: shared constants, payload structs,
// controller types and the dimension clamp function.
// No dependencies; every other file of the block but bfis_stream_if uses it by scoped names.
package bfis_pkg;

    localparam int CFG_W          = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int PIX_W          = 8;
    localparam int CNT_W          = 14;
    localparam int SUM_W          = 22;
    localparam int DIV_NUM_W      = 22;
    localparam int DIV_DEN_W      = 14;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_TARGET_WIDTH  = 2'd2,
        REG_TARGET_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_WALK,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_BOX_W,
        OP_BOX_H,
        OP_START_X,
        OP_START_Y,
        OP_RED,
        OP_GREEN,
        OP_BLUE
    } div_op_t;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             image_done;
    } out_item_t;

    typedef struct packed {
        logic    in_ready;
        logic    div_start;
        div_op_t div_op;
        logic    walk_init;
        logic    walk_issue;
        logic    emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic walk_last;
        logic out_free;
    } ctrl_status_t;

    // A zero dimension acts as one; a dimension above the limit acts as the limit.
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int limit);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CFG_W'(1);
        end
        else if (int'(v) > limit)
        begin
            r = CFG_W'(limit);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/bfis_stream_if.sv @@
// Valid/ready stream interface used for the item and result channels.
// The payload type is set per instance; depends on nothing else.
interface bfis_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/bfis_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on bfis_pkg for the operand widths.
module bfis_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bfis_pkg::DIV_NUM_W-1:0] num,
    input  logic [bfis_pkg::DIV_DEN_W-1:0] den,
    output logic [bfis_pkg::DIV_NUM_W-1:0] quotient,
    output logic                           busy,
    output logic                           done
);
    localparam int NUM_W  = bfis_pkg::DIV_NUM_W;
    localparam int DEN_W  = bfis_pkg::DIV_DEN_W;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    shifted;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            step_next = STEP_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? DEN_W'(shifted - {1'b0, den_reg}) : DEN_W'(shifted);
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

@@ rtl/core/bfis_ctrl.sv @@
// Controller state machine of the box filter scaler: sequences the divisions,
// the box walk and the result hand-off. Depends on bfis_pkg.
module bfis_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_func,
    input  bfis_pkg::ctrl_status_t status,
    output bfis_pkg::ctrl_cmd_t    cmd
);
    bfis_pkg::ctrl_state_t state_reg, state_next;
    bfis_pkg::div_op_t     op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            bfis_pkg::ST_IDLE:
            begin
                if (in_valid && in_func)
                begin
                    state_next = bfis_pkg::ST_DIV_GO;
                    op_next    = bfis_pkg::OP_BOX_W;
                end
            end
            bfis_pkg::ST_DIV_GO:
            begin
                state_next = bfis_pkg::ST_DIV_WAIT;
            end
            bfis_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    unique case (op_reg)
                        bfis_pkg::OP_BOX_W:
                        begin
                            op_next    = bfis_pkg::OP_BOX_H;
                            state_next = bfis_pkg::ST_DIV_GO;
                        end
                        bfis_pkg::OP_BOX_H:
                        begin
                            op_next    = bfis_pkg::OP_START_X;
                            state_next = bfis_pkg::ST_DIV_GO;
                        end
                        bfis_pkg::OP_START_X:
                        begin
                            op_next    = bfis_pkg::OP_START_Y;
                            state_next = bfis_pkg::ST_DIV_GO;
                        end
                        bfis_pkg::OP_START_Y:
                        begin
                            state_next = bfis_pkg::ST_WALK;
                        end
                        bfis_pkg::OP_RED:
                        begin
                            op_next    = bfis_pkg::OP_GREEN;
                            state_next = bfis_pkg::ST_DIV_GO;
                        end
                        bfis_pkg::OP_GREEN:
                        begin
                            op_next    = bfis_pkg::OP_BLUE;
                            state_next = bfis_pkg::ST_DIV_GO;
                        end
                        bfis_pkg::OP_BLUE:
                        begin
                            state_next = bfis_pkg::ST_EMIT;
                        end
                        default:
                        begin
                            state_next = bfis_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bfis_pkg::ST_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = bfis_pkg::ST_DRAIN1;
                end
            end
            bfis_pkg::ST_DRAIN1:
            begin
                state_next = bfis_pkg::ST_DRAIN2;
            end
            bfis_pkg::ST_DRAIN2:
            begin
                // The last sample is summed as this state ends; the channel divisions follow.
                state_next = bfis_pkg::ST_DIV_GO;
                op_next    = bfis_pkg::OP_RED;
            end
            bfis_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = bfis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfis_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.div_op     = op_reg;
        cmd.in_ready   = (state_reg == bfis_pkg::ST_IDLE);
        cmd.div_start  = (state_reg == bfis_pkg::ST_DIV_GO);
        cmd.walk_init  = (state_reg == bfis_pkg::ST_DIV_WAIT) && status.div_done
                         && (op_reg == bfis_pkg::OP_START_Y);
        cmd.walk_issue = (state_reg == bfis_pkg::ST_WALK);
        cmd.emit       = (state_reg == bfis_pkg::ST_EMIT) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfis_pkg::ST_IDLE;
            op_reg    <= bfis_pkg::OP_BOX_W;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == bfis_pkg::ST_DIV_WAIT))
        else $error("division finished outside the wait state");

    a_emit_after_blue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (op_reg == bfis_pkg::OP_BLUE))
        else $error("result emitted before the channel divisions finished");

endmodule

@@ rtl/core/bfis_datapath.sv @@
// Datapath of the box filter scaler: configuration registers, source memory,
// box walk with sums, the shared divider and the result register.
// Depends on bfis_pkg and bfis_divider.
module bfis_datapath #(
    parameter int MAX_WIDTH  = bfis_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bfis_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bfis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfis_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    input  bfis_pkg::in_item_t              in_item,
    input  logic                            out_ready,
    output logic                            out_valid,
    output bfis_pkg::out_item_t             out_item,
    input  bfis_pkg::ctrl_cmd_t             cmd,
    output bfis_pkg::ctrl_status_t          status
);
    localparam int CFG_W     = bfis_pkg::CFG_W;
    localparam int PIX_W     = bfis_pkg::PIX_W;
    localparam int CNT_W     = bfis_pkg::CNT_W;
    localparam int SUM_W     = bfis_pkg::SUM_W;
    localparam int NUM_W     = bfis_pkg::DIV_NUM_W;
    localparam int DEN_W     = bfis_pkg::DIV_DEN_W;
    localparam int PIX_COUNT = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W    = $clog2(PIX_COUNT);
    localparam int POS_W     = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
    localparam int WADDR_W   = 2 * CFG_W + 1;

    // Configuration.
    logic [CFG_W-1:0] sw_cfg_reg, sh_cfg_reg, tw_cfg_reg, th_cfg_reg;
    logic [CFG_W-1:0] sw, sh, tw, th;
    logic [CNT_W-1:0] total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_cfg_reg <= bfis_pkg::DIM_RESET;
            sh_cfg_reg <= bfis_pkg::DIM_RESET;
            tw_cfg_reg <= bfis_pkg::DIM_RESET;
            th_cfg_reg <= bfis_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (bfis_pkg::cfg_reg_t'(cfg_index))
                bfis_pkg::REG_SOURCE_WIDTH:  sw_cfg_reg <= cfg_data;
                bfis_pkg::REG_SOURCE_HEIGHT: sh_cfg_reg <= cfg_data;
                bfis_pkg::REG_TARGET_WIDTH:  tw_cfg_reg <= cfg_data;
                bfis_pkg::REG_TARGET_HEIGHT: th_cfg_reg <= cfg_data;
            endcase
        end
    end

    assign sw    = bfis_pkg::clamp_dim(sw_cfg_reg, MAX_WIDTH);
    assign sh    = bfis_pkg::clamp_dim(sh_cfg_reg, MAX_HEIGHT);
    assign tw    = bfis_pkg::clamp_dim(tw_cfg_reg, MAX_WIDTH);
    assign th    = bfis_pkg::clamp_dim(th_cfg_reg, MAX_HEIGHT);
    assign total = CNT_W'(sw) * CNT_W'(sh);

    // Source loading, column-major.
    logic [ADDR_W-1:0] load_pos_reg, load_pos_next;
    logic [ADDR_W-1:0] pos_eff;
    logic [POS_W-1:0]  pos_inc;
    logic              load_fire;

    assign load_fire = in_valid && cmd.in_ready && !in_item.func;
    assign pos_eff   = (POS_W'(load_pos_reg) < POS_W'(total)) ? load_pos_reg : '0;
    assign pos_inc   = POS_W'(pos_eff) + POS_W'(1);
    assign load_pos_next = (pos_inc >= POS_W'(total)) ? '0 : ADDR_W'(pos_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
        end
        else if (load_fire)
        begin
            load_pos_reg <= load_pos_next;
        end
    end

    // Target position; a counter outside the current dimension acts as zero.
    logic [CFG_W-1:0] col_reg, row_reg, col_eff, row_eff;
    logic [CFG_W-1:0] col_next, row_next;
    logic [CFG_W:0]   col_inc, row_inc;
    logic             done_flag;

    assign col_eff = (col_reg < tw) ? col_reg : '0;
    assign row_eff = (row_reg < th) ? row_reg : '0;
    assign col_inc = {1'b0, col_eff} + 1'b1;
    assign row_inc = {1'b0, row_eff} + 1'b1;

    always_comb
    begin
        col_next  = col_eff;
        row_next  = CFG_W'(row_inc);
        done_flag = 1'b0;
        if (row_inc >= {1'b0, th})
        begin
            row_next = '0;
            col_next = CFG_W'(col_inc);
            if (col_inc >= {1'b0, tw})
            begin
                col_next  = '0;
                done_flag = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.emit)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Shared divider and its operand selection.
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] div_q;
    logic             div_busy, div_done;
    logic [CNT_W-1:0] prod_x, prod_y;
    logic [SUM_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [CNT_W-1:0] count_reg;

    assign prod_x = CNT_W'(col_eff) * CNT_W'(sw);
    assign prod_y = CNT_W'(row_eff) * CNT_W'(sh);

    // Rounded quotients use (2a + b) / (2b).
    always_comb
    begin
        unique case (cmd.div_op)
            bfis_pkg::OP_BOX_W:
            begin
                div_num = NUM_W'({sw, 1'b0}) + NUM_W'(tw);
                div_den = DEN_W'({tw, 1'b0});
            end
            bfis_pkg::OP_BOX_H:
            begin
                div_num = NUM_W'({sh, 1'b0}) + NUM_W'(th);
                div_den = DEN_W'({th, 1'b0});
            end
            bfis_pkg::OP_START_X:
            begin
                div_num = NUM_W'({prod_x, 1'b0}) + NUM_W'(tw);
                div_den = DEN_W'({tw, 1'b0});
            end
            bfis_pkg::OP_START_Y:
            begin
                div_num = NUM_W'({prod_y, 1'b0}) + NUM_W'(th);
                div_den = DEN_W'({th, 1'b0});
            end
            bfis_pkg::OP_RED:
            begin
                div_num = sum_r_reg;
                div_den = count_reg;
            end
            bfis_pkg::OP_GREEN:
            begin
                div_num = sum_g_reg;
                div_den = count_reg;
            end
            bfis_pkg::OP_BLUE:
            begin
                div_num = sum_b_reg;
                div_den = count_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    bfis_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .quotient (div_q),
        .busy     (div_busy),
        .done     (div_done)
    );

    logic [CFG_W-1:0] box_w_reg, box_h_reg, start_x_reg, start_y_reg;
    logic [PIX_W-1:0] res_r_reg, res_g_reg, res_b_reg;
    logic [PIX_W-1:0] q_pix;
    logic [CFG_W-1:0] q_box;

    // An empty box gives zero; a box size that rounds to zero is raised to one.
    assign q_pix = (count_reg == '0) ? '0 : PIX_W'(div_q);
    assign q_box = (div_q == '0) ? CFG_W'(1) : CFG_W'(div_q);

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            unique case (cmd.div_op)
                bfis_pkg::OP_BOX_W:   box_w_reg   <= q_box;
                bfis_pkg::OP_BOX_H:   box_h_reg   <= q_box;
                bfis_pkg::OP_START_X: start_x_reg <= CFG_W'(div_q);
                bfis_pkg::OP_START_Y: start_y_reg <= CFG_W'(div_q);
                bfis_pkg::OP_RED:     res_r_reg   <= q_pix;
                bfis_pkg::OP_GREEN:   res_g_reg   <= q_pix;
                bfis_pkg::OP_BLUE:    res_b_reg   <= q_pix;
                default:              res_r_reg   <= res_r_reg;
            endcase
        end
    end

    // Box walk: column outer, row inner; one memory read issued per cycle.
    logic [CFG_W-1:0]   bx_reg, by_reg;
    logic [CFG_W:0]     sx, sy;
    logic               in_range;
    logic [WADDR_W-1:0] walk_addr;
    logic [ADDR_W-1:0]  addr_reg;
    logic               hit_reg, rd_hit_reg;
    logic [3*PIX_W-1:0] rd_data_reg;
    logic [3*PIX_W-1:0] mem [PIX_COUNT];

    assign sx        = {1'b0, start_x_reg} + {1'b0, bx_reg};
    assign sy        = {1'b0, start_y_reg} + {1'b0, by_reg};
    assign in_range  = (sx < {1'b0, sw}) && (sy < {1'b0, sh});
    assign walk_addr = WADDR_W'(sx) * WADDR_W'(sh) + WADDR_W'(sy);

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            bx_reg <= '0;
            by_reg <= '0;
        end
        else if (cmd.walk_issue)
        begin
            if (by_reg == box_h_reg - CFG_W'(1))
            begin
                by_reg <= '0;
                bx_reg <= bx_reg + CFG_W'(1);
            end
            else
            begin
                by_reg <= by_reg + CFG_W'(1);
            end
        end
        addr_reg <= ADDR_W'(walk_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg    <= 1'b0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg    <= cmd.walk_issue && in_range;
            rd_hit_reg <= hit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            mem[pos_eff] <= {in_item.in_red, in_item.in_green, in_item.in_blue};
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
            count_reg <= '0;
        end
        else if (rd_hit_reg)
        begin
            sum_r_reg <= sum_r_reg + SUM_W'(rd_data_reg[3*PIX_W-1:2*PIX_W]);
            sum_g_reg <= sum_g_reg + SUM_W'(rd_data_reg[2*PIX_W-1:PIX_W]);
            sum_b_reg <= sum_b_reg + SUM_W'(rd_data_reg[PIX_W-1:0]);
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Result register parts the walk from the result channel.
    logic                out_valid_reg;
    bfis_pkg::out_item_t out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item_reg.out_red    <= res_r_reg;
            out_item_reg.out_green  <= res_g_reg;
            out_item_reg.out_blue   <= res_b_reg;
            out_item_reg.image_done <= done_flag;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign status.div_busy  = div_busy;
    assign status.div_done  = div_done;
    assign status.walk_last = (bx_reg == box_w_reg - CFG_W'(1))
                              && (by_reg == box_h_reg - CFG_W'(1));
    assign status.out_free  = !out_valid_reg || out_ready;

    a_hit_inside_image: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> (POS_W'(addr_reg) < POS_W'(total)))
        else $error("box sample address lies outside the loaded image");

    a_box_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_issue |-> (box_w_reg != '0) && (box_h_reg != '0))
        else $error("box walk with a zero box size");

endmodule

@@ rtl/core/box_filter_image_scaler_top.sv @@
// Top level of the box filter image scaler.
// Depends on bfis_pkg, bfis_stream_if, bfis_ctrl and bfis_datapath.
//
// A load item (func 0) writes one source pixel in column-major order and is
// taken with no result. A fetch item (func 1) produces one destination pixel,
// also column-major, that averages its source box; no further item is taken
// until the controller is back in idle. Seven divisions (box width and height,
// box start column and row, and the three channel averages) run one after
// another on a shared divider. Each division has a start state, 22 steps that
// retire one quotient bit each, and a hand-over of the quotient. The box walk
// reads one source pixel per cycle through the single read port of the source
// memory and then drains the read pipeline in the states DRAIN1 and DRAIN2.
// The item is taken in the idle state and the result is handed off in the emit
// state. A finished result waits in an output register, so the next item is
// taken while it is pending; a following fetch holds its result until that
// register is free.
module box_filter_image_scaler_top #(
    parameter int MAX_WIDTH  = bfis_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bfis_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bfis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfis_pkg::CFG_W-1:0]     cfg_data,
    bfis_stream_if.sink                    items,
    bfis_stream_if.source                  results
);
    bfis_pkg::ctrl_cmd_t    cmd;
    bfis_pkg::ctrl_status_t status;
    bfis_pkg::in_item_t     in_item;
    bfis_pkg::out_item_t    out_item;
    logic                   out_valid;

    assign in_item         = items.payload;
    assign items.ready     = cmd.in_ready;
    assign results.valid   = out_valid;
    assign results.payload = out_item;

    bfis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_func  (in_item.func),
        .status   (status),
        .cmd      (cmd)
    );

    bfis_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (items.valid),
        .in_item   (in_item),
        .out_ready (results.ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ sim/box_filter_image_scaler_top_tb.sv @@
// Self-checking testbench for box_filter_image_scaler_top: loads source images, fetches
// box-averaged pixels under random idling and back-pressure, and checks every result.
// Depends on bfis_pkg, bfis_stream_if and the RTL of the block.
`timescale 1ns / 1ps

module box_filter_image_scaler_top_tb;

    localparam int   CFG_W               = bfis_pkg::CFG_W;
    localparam int   CFG_IDX_W           = bfis_pkg::CFG_IDX_W;
    localparam logic FUNC_LOAD           = 1'b0;
    localparam logic FUNC_FETCH          = 1'b1;
    localparam int   MEM_DEPTH           = bfis_pkg::MAX_WIDTH_DEF * bfis_pkg::MAX_HEIGHT_DEF;
    localparam int   ITEM_TARGET         = 1550;
    localparam int   MAX_GAP             = 19;
    localparam int   BACKPRESSURE_CYCLES = 800;
    // Quiet cycles allowed: the largest box walk plus divisions, stalls and settling.
    localparam int   IDLE_LIMIT          = 30000;
    // Only loads can still be in flight once the last result is out.
    localparam int   SETTLE_CYCLES       = 7 * 24 + 6 + 16;

    class pixel_average_scoreboard;
        logic [23:0]         source_mem [MEM_DEPTH];
        bit                  loaded [MEM_DEPTH];
        logic [CFG_W-1:0]    dims [4];
        int unsigned         load_pos;
        int unsigned         col;
        int unsigned         row;
        bfis_pkg::out_item_t pending_pixels [$];
        int                  errors;
        int                  loads;
        int                  fetches;
        int                  images;
        int                  empty_boxes;
        int                  checked;

        function new();
            dims = '{bfis_pkg::DIM_RESET, bfis_pkg::DIM_RESET,
                     bfis_pkg::DIM_RESET, bfis_pkg::DIM_RESET};
            load_pos = 0;
            col = 0;
            row = 0;
        endfunction

        function void write_reg(bfis_pkg::cfg_reg_t idx, logic [CFG_W-1:0] v);
            dims[int'(idx)] = v;
        endfunction

        function int unsigned dim(bfis_pkg::cfg_reg_t idx);
            int unsigned v;
            int unsigned lim;
            v = 32'(dims[int'(idx)]);
            lim = (idx == bfis_pkg::REG_SOURCE_WIDTH || idx == bfis_pkg::REG_TARGET_WIDTH) ?
                  bfis_pkg::MAX_WIDTH_DEF : bfis_pkg::MAX_HEIGHT_DEF;
            if (v == 0)
                return 1;
            if (v > lim)
                return lim;
            return v;
        endfunction

        function int unsigned half_up(int unsigned num, int unsigned den);
            return (2 * num + den) / (2 * den);
        endfunction

        // Position and box of the next destination pixel.
        function void next_box(output int unsigned x, output int unsigned y,
                               output int unsigned x0, output int unsigned y0,
                               output int unsigned bw, output int unsigned bh);
            int unsigned sw;
            int unsigned sh;
            int unsigned tw;
            int unsigned th;
            sw = dim(bfis_pkg::REG_SOURCE_WIDTH);
            sh = dim(bfis_pkg::REG_SOURCE_HEIGHT);
            tw = dim(bfis_pkg::REG_TARGET_WIDTH);
            th = dim(bfis_pkg::REG_TARGET_HEIGHT);
            x = (col < tw) ? col : 0;
            y = (row < th) ? row : 0;
            bw = half_up(sw, tw);
            bh = half_up(sh, th);
            if (bw == 0)
                bw = 1;
            if (bh == 0)
                bh = 1;
            x0 = half_up(x * sw, tw);
            y0 = half_up(y * sh, th);
        endfunction

        // True when every in-range sample of the next box has been loaded.
        function bit fetch_is_safe();
            int unsigned x;
            int unsigned y;
            int unsigned x0;
            int unsigned y0;
            int unsigned bw;
            int unsigned bh;
            int unsigned sw;
            int unsigned sh;
            next_box(x, y, x0, y0, bw, bh);
            sw = dim(bfis_pkg::REG_SOURCE_WIDTH);
            sh = dim(bfis_pkg::REG_SOURCE_HEIGHT);
            for (int unsigned i = 0; i < bw; i++)
            begin
                for (int unsigned j = 0; j < bh; j++)
                begin
                    if (x0 + i < sw && y0 + j < sh && !loaded[(x0 + i) * sh + y0 + j])
                        return 0;
                end
            end
            return 1;
        endfunction

        function void accept_item(bfis_pkg::in_item_t it);
            int unsigned sw;
            int unsigned sh;
            int unsigned tw;
            int unsigned th;
            int unsigned total;
            int unsigned pos;
            int unsigned x;
            int unsigned y;
            int unsigned x0;
            int unsigned y0;
            int unsigned bw;
            int unsigned bh;
            int unsigned n;
            int unsigned red;
            int unsigned green;
            int unsigned blue;
            logic [23:0] px;
            bfis_pkg::out_item_t want;
            sw = dim(bfis_pkg::REG_SOURCE_WIDTH);
            sh = dim(bfis_pkg::REG_SOURCE_HEIGHT);
            tw = dim(bfis_pkg::REG_TARGET_WIDTH);
            th = dim(bfis_pkg::REG_TARGET_HEIGHT);
            if (it.func == FUNC_LOAD)
            begin
                total = sw * sh;
                pos = (load_pos < total) ? load_pos : 0;
                source_mem[pos] = {it.in_red, it.in_green, it.in_blue};
                loaded[pos] = 1'b1;
                load_pos = (pos + 1 >= total) ? 0 : pos + 1;
                loads++;
                return;
            end
            next_box(x, y, x0, y0, bw, bh);
            red = 0;
            green = 0;
            blue = 0;
            n = 0;
            for (int unsigned j = 0; j < bh; j++)
            begin
                for (int unsigned i = 0; i < bw; i++)
                begin
                    if (x0 + i < sw && y0 + j < sh)
                    begin
                        px = source_mem[(x0 + i) * sh + y0 + j];
                        red += 32'(px[23:16]);
                        green += 32'(px[15:8]);
                        blue += 32'(px[7:0]);
                        n++;
                    end
                end
            end
            if (n != 0)
            begin
                red /= n;
                green /= n;
                blue /= n;
            end
            else
            begin
                empty_boxes++;
            end
            want.out_red = 8'(red);
            want.out_green = 8'(green);
            want.out_blue = 8'(blue);
            want.image_done = 1'b0;
            // Column-major walk: the row advances first.
            y++;
            if (y >= th)
            begin
                y = 0;
                x++;
                if (x >= tw)
                begin
                    x = 0;
                    want.image_done = 1'b1;
                    images++;
                end
            end
            row = y;
            col = x;
            fetches++;
            pending_pixels.push_back(want);
        endfunction

        function void check_pixel(bfis_pkg::out_item_t got);
            bfis_pkg::out_item_t want;
            checked++;
            if (pending_pixels.size() == 0)
            begin
                $error("Result transaction with no fetch outstanding: %p", got);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.out_red !== want.out_red)
            begin
                $error("out_red: expected %0d, actual %0d", want.out_red, got.out_red);
                errors++;
            end
            if (got.out_green !== want.out_green)
            begin
                $error("out_green: expected %0d, actual %0d", want.out_green, got.out_green);
                errors++;
            end
            if (got.out_blue !== want.out_blue)
            begin
                $error("out_blue: expected %0d, actual %0d", want.out_blue, got.out_blue);
                errors++;
            end
            if (got.image_done !== want.image_done)
            begin
                $error("image_done: expected %0d, actual %0d", want.image_done, got.image_done);
                errors++;
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    bfis_stream_if #(.payload_t(bfis_pkg::in_item_t))  items_if ();
    bfis_stream_if #(.payload_t(bfis_pkg::out_item_t)) results_if ();

    box_filter_image_scaler_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items_if.sink),
        .results   (results_if.source)
    );

    pixel_average_scoreboard board = new();
    int items_sent;
    int settings_used;
    int quiet_cycles;
    bit sender_burst;

    always #5 clk = ~clk;

    task automatic send_item(input bfis_pkg::in_item_t it);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            items_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.payload <= it;
        do
            @(posedge clk);
        while (!items_if.ready);
        board.accept_item(it);
        items_sent++;
    endtask

    task automatic send_pixel(input logic func, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        bfis_pkg::in_item_t it;
        it.func = func;
        it.in_red = r;
        it.in_green = g;
        it.in_blue = b;
        send_item(it);
    endtask

    task automatic write_register(input bfis_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        board.write_reg(idx, v);
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                                 input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th);
        write_register(bfis_pkg::REG_SOURCE_WIDTH, sw);
        write_register(bfis_pkg::REG_SOURCE_HEIGHT, sh);
        write_register(bfis_pkg::REG_TARGET_WIDTH, tw);
        write_register(bfis_pkg::REG_TARGET_HEIGHT, th);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Lower valid, drain every outstanding result, then let trailing loads retire.
    task automatic settle();
        items_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 7'd127;
            2: return 7'd64;
            3: return CFG_W'($urandom_range(1, 64));
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    initial
    begin
        bfis_pkg::in_item_t it;
        int                 phase_len;
        int                 fetch_pct;
        cfg_we = 1'b0;
        cfg_index = bfis_pkg::REG_SOURCE_WIDTH;
        cfg_data = '0;
        items_if.valid = 1'b0;
        items_if.payload = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 2x2 source into one pixel: the box covers the whole image, so each fetch ends it.
        apply_setting(7'd2, 7'd2, 7'd1, 7'd1);
        send_pixel(FUNC_LOAD, 8'hFF, 8'h00, 8'hAA);
        send_pixel(FUNC_LOAD, 8'hFF, 8'hFF, 8'h55);
        send_pixel(FUNC_LOAD, 8'h00, 8'hFF, 8'h00);
        send_pixel(FUNC_LOAD, 8'hFF, 8'h00, 8'hFF);
        send_pixel(FUNC_FETCH, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(FUNC_FETCH, 8'h00, 8'h00, 8'h00);
        send_pixel(FUNC_LOAD, 8'h01, 8'h80, 8'h7F);
        send_pixel(FUNC_LOAD, 8'hFE, 8'h7F, 8'h80);
        send_pixel(FUNC_LOAD, 8'h00, 8'h00, 8'h00);
        settle();

        // The load pointer now sits past the smaller image, and half steps round up:
        // the second column box runs off the edge and the second row box is empty.
        apply_setting(7'd3, 7'd1, 7'd2, 7'd2);
        send_pixel(FUNC_LOAD, 8'h10, 8'hC0, 8'h33);
        send_pixel(FUNC_LOAD, 8'hEF, 8'h3F, 8'hCC);
        send_pixel(FUNC_LOAD, 8'h80, 8'h01, 8'hFE);
        send_pixel(FUNC_FETCH, 8'hAA, 8'h55, 8'hAA);
        send_pixel(FUNC_FETCH, 8'h55, 8'hAA, 8'h55);
        send_pixel(FUNC_FETCH, 8'hFF, 8'h00, 8'hFF);
        settle();

        // Zero dimensions act as one, and the destination counters are out of range.
        apply_setting(7'd0, 7'd3, 7'd1, 7'd0);
        send_pixel(FUNC_FETCH, 8'h00, 8'hFF, 8'h00);
        send_pixel(FUNC_FETCH, 8'hFF, 8'h00, 8'hFF);

        while (items_sent < ITEM_TARGET)
        begin
            settle();
            phase_len = $urandom_range(20, 120);
            fetch_pct = $urandom_range(15, 85);
            if (settings_used == 3)
            begin
                apply_setting(7'd127, 7'd0, 7'd0, 7'd127);
                phase_len = 160;
                fetch_pct = 50;
            end
            else if (settings_used == 4)
            begin
                apply_setting(7'd1, 7'd64, 7'd64, 7'd1);
                phase_len = 160;
                fetch_pct = 50;
            end
            else
            begin
                apply_setting(pick_dim(), pick_dim(), pick_dim(), pick_dim());
            end
            sender_burst = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                it.in_red = 8'($urandom);
                it.in_green = 8'($urandom);
                it.in_blue = 8'($urandom);
                // A fetch goes out only once every in-range sample of its box has been loaded.
                if ($urandom_range(0, 99) < fetch_pct && board.fetch_is_safe())
                    it.func = FUNC_FETCH;
                else
                    it.func = FUNC_LOAD;
                send_item(it);
            end
        end
        settle();

        $display("Covered %0d loads and %0d fetches over %0d register settings;",
                 board.loads, board.fetches, settings_used);
        $display("%0d destination images completed, %0d fetches hit an empty box.",
                 board.images, board.empty_boxes);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("PASS box_filter_image_scaler_top");
        end
        else
        begin
            $display("FAIL box_filter_image_scaler_top");
        end
        $finish;
    end

    // Result side: random stalls, calm stretches, and two long hold-offs that back the
    // block up into its input.
    initial
    begin
        int stall;
        bit steady;
        stall = 0;
        steady = 1'b0;
        results_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            results_if.ready <= (stall == 0);
            @(posedge clk);
            if (results_if.valid && results_if.ready)
            begin
                board.check_pixel(results_if.payload);
                if (board.checked % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                if (board.checked == 25 || board.checked == 300)
                    stall = BACKPRESSURE_CYCLES;
                else
                    stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            else if (stall > 0)
            begin
                stall--;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL box_filter_image_scaler_top");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
        quiet_cycles = 0;

endmodule

@@ box_filter_image_scaler_top.f @@
rtl/core/bfis_pkg.sv
rtl/core/bfis_stream_if.sv
rtl/core/bfis_divider.sv
rtl/core/bfis_ctrl.sv
rtl/core/bfis_datapath.sv
rtl/core/box_filter_image_scaler_top.sv
sim/box_filter_image_scaler_top_tb.sv
